FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that holds at every clock edge once reset is released.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle implies a condition in the next.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/dtfe_pkg.sv
package dtfe_pkg;

  localparam int KIND_W  = 2;
  localparam int FLD_W   = 3;
  localparam int BTN_W   = 2;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  // Offsets inside a field's range; the widest range is the year span, at most 255.
  localparam int OFF_W   = 8;

  localparam int YEAR_FIRST_DEF = 2020;
  localparam int YEAR_LAST_DEF  = 2099;

  localparam int BIG_STEP       = 10;
  localparam int BIG_STEP_MONTH = 3;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SELECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STEP   = 2'd2;

  localparam logic [FLD_W-1:0] FLD_YEAR   = 3'd0;
  localparam logic [FLD_W-1:0] FLD_MONTH  = 3'd1;
  localparam logic [FLD_W-1:0] FLD_DAY    = 3'd2;
  localparam logic [FLD_W-1:0] FLD_HOUR   = 3'd3;
  localparam logic [FLD_W-1:0] FLD_MINUTE = 3'd4;

  localparam logic [BTN_W-1:0] BTN_MINUS_BIG   = 2'd0;
  localparam logic [BTN_W-1:0] BTN_MINUS_SMALL = 2'd1;
  localparam logic [BTN_W-1:0] BTN_PLUS_SMALL  = 2'd2;
  localparam logic [BTN_W-1:0] BTN_PLUS_BIG    = 2'd3;

  localparam logic [MONTH_W-1:0] MONTH_MAX  = 4'd12;
  localparam logic [HOUR_W-1:0]  HOUR_MAX   = 5'd23;
  localparam logic [MIN_W-1:0]   MINUTE_MAX = 6'd59;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FLD_W-1:0]   field_pick;
    logic [BTN_W-1:0]   button;
    logic [YEAR_W-1:0]  load_year;
    logic [MONTH_W-1:0] load_month;
    logic [DAY_W-1:0]   load_day;
    logic [HOUR_W-1:0]  load_hour;
    logic [MIN_W-1:0]   load_minute;
  } item_t;

  // Gregorian month length. The century rule is applied only to 2100, so the
  // result is exact for every year from 1901 through 2199.
  function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0] y,
                                                  input logic [MONTH_W-1:0] m);
    logic leap;
    leap = (y[1:0] == 2'b00) && (y != 12'd2100);
    case (m) inside
      4'd2:                   month_days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
      default:                month_days = 5'd31;
    endcase
  endfunction

endpackage

FILE: rtl/dtfe_if.sv
interface dtfe_in_if import dtfe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [FLD_W-1:0]   field_pick;
  logic [BTN_W-1:0]   button;
  logic [YEAR_W-1:0]  load_year;
  logic [MONTH_W-1:0] load_month;
  logic [DAY_W-1:0]   load_day;
  logic [HOUR_W-1:0]  load_hour;
  logic [MIN_W-1:0]   load_minute;

  modport source (output valid, kind, field_pick, button, load_year, load_month,
                  load_day, load_hour, load_minute, input ready);
  modport sink (input valid, kind, field_pick, button, load_year, load_month,
                load_day, load_hour, load_minute, output ready);
endinterface

interface dtfe_out_if import dtfe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year_out;
  logic [MONTH_W-1:0] month_out;
  logic [DAY_W-1:0]   day_out;
  logic [HOUR_W-1:0]  hour_out;
  logic [MIN_W-1:0]   minute_out;
  logic [FLD_W-1:0]   selected_out;

  modport source (output valid, year_out, month_out, day_out, hour_out, minute_out,
                  selected_out, input ready);
  modport sink (input valid, year_out, month_out, day_out, hour_out, minute_out,
                selected_out, output ready);
endinterface

FILE: rtl/dtfe_in_reg.sv
module dtfe_in_reg import dtfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dtfe_in_if.sink    in_bus,
  output item_t      item_o,
  output logic       item_valid_o,
  input  logic       item_ready_i
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  // The register takes a new beat whenever it is empty or being drained.
  assign in_bus.ready = !valid_r || item_ready_i;
  assign valid_nxt    = in_bus.ready ? in_bus.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_r.kind        <= in_bus.kind;
      item_r.field_pick  <= in_bus.field_pick;
      item_r.button      <= in_bus.button;
      item_r.load_year   <= in_bus.load_year;
      item_r.load_month  <= in_bus.load_month;
      item_r.load_day    <= in_bus.load_day;
      item_r.load_hour   <= in_bus.load_hour;
      item_r.load_minute <= in_bus.load_minute;
    end
  end

  assign item_o       = item_r;
  assign item_valid_o = valid_r;

endmodule

FILE: rtl/dtfe_edit.sv
`include "assert_macros.svh"

module dtfe_edit import dtfe_pkg::*; #(
  parameter int YEAR_FIRST = YEAR_FIRST_DEF,
  parameter int YEAR_LAST  = YEAR_LAST_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  item_t      item_i,
  input  logic       item_valid_i,
  output logic       item_ready_o,
  dtfe_out_if.source out_bus
);

  localparam int YEAR_HI       = (YEAR_LAST < YEAR_FIRST) ? YEAR_FIRST : YEAR_LAST;
  localparam int YEAR_SPAN     = YEAR_HI - YEAR_FIRST + 1;
  // Year steps reduced into the span so that one wrap correction is enough.
  localparam int YEAR_BIG_UP   = BIG_STEP % YEAR_SPAN;
  localparam int YEAR_BIG_DN   = (YEAR_SPAN - YEAR_BIG_UP) % YEAR_SPAN;
  localparam int YEAR_SMALL_UP = 1 % YEAR_SPAN;
  localparam int YEAR_SMALL_DN = (YEAR_SPAN - YEAR_SMALL_UP) % YEAR_SPAN;

  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [HOUR_W-1:0]  hour_r, hour_nxt;
  logic [MIN_W-1:0]   minute_r, minute_nxt;
  logic [FLD_W-1:0]   sel_r, sel_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               take;

  logic [OFF_W-1:0]   off, span, big, amt, wrapped;
  logic [OFF_W:0]     sum_raw;
  logic [DAY_W-1:0]   dim_cur, dim_year_step, dim_month_step, dim_load;
  logic [YEAR_W-1:0]  step_year, ld_year;
  logic [MONTH_W-1:0] step_month, ld_month;
  logic [DAY_W-1:0]   ld_day;
  logic [HOUR_W-1:0]  ld_hour;
  logic [MIN_W-1:0]   ld_minute;

  // The state registers double as the result register; they only move when
  // the previous result has left or is leaving.
  assign item_ready_o = !out_valid_r || out_bus.ready;
  assign take         = item_valid_i && item_ready_o;

  // Step: offset inside the field, add a step already reduced into the span,
  // and fold back once.
  always_comb begin
    dim_cur = month_days(year_r, month_r);
    unique case (sel_r)
      FLD_YEAR: begin
        off  = OFF_W'(year_r - YEAR_W'(YEAR_FIRST));
        span = OFF_W'(YEAR_SPAN);
      end
      FLD_MONTH: begin
        off  = OFF_W'(month_r - 4'd1);
        span = OFF_W'(MONTH_MAX);
      end
      FLD_DAY: begin
        off  = OFF_W'(day_r - 5'd1);
        span = OFF_W'(dim_cur);
      end
      FLD_HOUR: begin
        off  = OFF_W'(hour_r);
        span = OFF_W'(HOUR_MAX) + 8'd1;
      end
      default: begin
        off  = OFF_W'(minute_r);
        span = OFF_W'(MINUTE_MAX) + 8'd1;
      end
    endcase

    big = (sel_r == FLD_MONTH) ? OFF_W'(BIG_STEP_MONTH) : OFF_W'(BIG_STEP);
    if (sel_r == FLD_YEAR) begin
      case (item_i.button)
        BTN_MINUS_BIG:   amt = OFF_W'(YEAR_BIG_DN);
        BTN_MINUS_SMALL: amt = OFF_W'(YEAR_SMALL_DN);
        BTN_PLUS_SMALL:  amt = OFF_W'(YEAR_SMALL_UP);
        default:         amt = OFF_W'(YEAR_BIG_UP);
      endcase
    end else begin
      case (item_i.button)
        BTN_MINUS_BIG:   amt = span - big;
        BTN_MINUS_SMALL: amt = span - 8'd1;
        BTN_PLUS_SMALL:  amt = 8'd1;
        default:         amt = big;
      endcase
    end

    sum_raw = {1'b0, off} + {1'b0, amt};
    if (sum_raw >= {1'b0, span}) begin
      wrapped = OFF_W'(sum_raw - {1'b0, span});
    end else begin
      wrapped = sum_raw[OFF_W-1:0];
    end

    step_year      = YEAR_W'(YEAR_FIRST) + YEAR_W'(wrapped);
    step_month     = MONTH_W'(wrapped) + 4'd1;
    dim_year_step  = month_days(step_year, month_r);
    dim_month_step = month_days(year_r, step_month);
  end

  // Load: saturate every loaded field into its range.
  always_comb begin
    if (item_i.load_year < YEAR_W'(YEAR_FIRST)) begin
      ld_year = YEAR_W'(YEAR_FIRST);
    end else if (item_i.load_year > YEAR_W'(YEAR_HI)) begin
      ld_year = YEAR_W'(YEAR_HI);
    end else begin
      ld_year = item_i.load_year;
    end
    if (item_i.load_month == 4'd0) begin
      ld_month = 4'd1;
    end else if (item_i.load_month > MONTH_MAX) begin
      ld_month = MONTH_MAX;
    end else begin
      ld_month = item_i.load_month;
    end
    dim_load = month_days(ld_year, ld_month);
    if (item_i.load_day == 5'd0) begin
      ld_day = 5'd1;
    end else if (item_i.load_day > dim_load) begin
      ld_day = dim_load;
    end else begin
      ld_day = item_i.load_day;
    end
    ld_hour   = (item_i.load_hour > HOUR_MAX) ? HOUR_MAX : item_i.load_hour;
    ld_minute = (item_i.load_minute > MINUTE_MAX) ? MINUTE_MAX : item_i.load_minute;
  end

  always_comb begin
    year_nxt      = year_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    if (take) begin
      out_valid_nxt = 1'b1;
      unique case (item_i.kind)
        KIND_LOAD: begin
          year_nxt   = ld_year;
          month_nxt  = ld_month;
          day_nxt    = ld_day;
          hour_nxt   = ld_hour;
          minute_nxt = ld_minute;
        end
        KIND_SELECT: begin
          if (item_i.field_pick <= FLD_MINUTE) begin
            sel_nxt = item_i.field_pick;
          end
        end
        KIND_STEP: begin
          unique case (sel_r)
            FLD_YEAR: begin
              year_nxt = step_year;
              day_nxt  = (day_r > dim_year_step) ? dim_year_step : day_r;
            end
            FLD_MONTH: begin
              month_nxt = step_month;
              day_nxt   = (day_r > dim_month_step) ? dim_month_step : day_r;
            end
            FLD_DAY:  day_nxt  = DAY_W'(wrapped) + 5'd1;
            FLD_HOUR: hour_nxt = HOUR_W'(wrapped);
            default:  minute_nxt = MIN_W'(wrapped);
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r      <= YEAR_W'(YEAR_FIRST);
      month_r     <= 4'd1;
      day_r       <= 5'd1;
      hour_r      <= '0;
      minute_r    <= '0;
      sel_r       <= FLD_HOUR;
      out_valid_r <= 1'b0;
    end else begin
      year_r      <= year_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      hour_r      <= hour_nxt;
      minute_r    <= minute_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.year_out     = year_r;
  assign out_bus.month_out    = month_r;
  assign out_bus.day_out      = day_r;
  assign out_bus.hour_out     = hour_r;
  assign out_bus.minute_out   = minute_r;
  assign out_bus.selected_out = sel_r;

  `ASSERT_ALWAYS(a_day_fits_month, day_r >= 5'd1 && day_r <= month_days(year_r, month_r), "day outside its month")
  `ASSERT_ALWAYS(a_year_in_range, year_r >= YEAR_W'(YEAR_FIRST) && year_r <= YEAR_W'(YEAR_HI), "year out of range")
  `ASSERT_ALWAYS(a_sel_legal, sel_r <= FLD_MINUTE, "selected field code out of range")
  `ASSERT_NEXT(a_select_taken, take && item_i.kind == KIND_SELECT && item_i.field_pick <= FLD_MINUTE, sel_r == $past(item_i.field_pick), "select beat not applied")
  `ASSERT_NEXT(a_take_gives_result, take, out_valid_r, "accepted beat produced no result")

endmodule

FILE: rtl/date_time_field_editor.sv
// A result beat passes the input register and then the edit state, which doubles
// as the result register; the add, wrap and day clamp are combinational.
// Throughput: one beat per cycle while out_bus.ready keeps results draining.
// Reset (synchronous, active low): year = YEAR_FIRST, month 1, day 1, 00:00,
// hour field selected, both stages empty.
module date_time_field_editor import dtfe_pkg::*; #(
  parameter int YEAR_FIRST = YEAR_FIRST_DEF,
  parameter int YEAR_LAST  = YEAR_LAST_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dtfe_in_if.sink    in_bus,
  dtfe_out_if.source out_bus
);

  item_t item;
  logic  item_valid;
  logic  item_ready;

  dtfe_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_bus       (in_bus),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  dtfe_edit #(
    .YEAR_FIRST (YEAR_FIRST),
    .YEAR_LAST  (YEAR_LAST)
  ) u_edit (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .out_bus      (out_bus)
  );

endmodule
